@@ rtl/swc_pkg.sv @@
`timescale 1ns / 1ps

package swc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int POS_W       = 12;
   localparam int SIZE_W      = 13;
   localparam int COEF_W      = 16;
   localparam int COEF_ROW_W  = 48;
   localparam int CSR_INDEX_W = 3;

   // An unsigned pixel times a signed Q4.12 coefficient, then sums of up to
   // three taps per kernel row and of up to three rows.
   localparam int PROD_W      = PIXEL_W + COEF_W + 1;
   localparam int ROW_SUM_W   = PROD_W + 2;
   localparam int SUM_W       = ROW_SUM_W + 2;

   localparam int MAX_SIZE     = 4096;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [COEF_ROW_W-1:0] COEF_TOP_RESET    = 48'h0000_0000_0000;
   localparam logic [COEF_ROW_W-1:0] COEF_MIDDLE_RESET = 48'h0000_1000_0000;
   localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RESET = 48'h0000_0000_0000;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_COEF_TOP     = 3'd2,
      CSR_COEF_MIDDLE  = 3'd3,
      CSR_COEF_BOTTOM  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_done;
   } tag_type;

   typedef struct packed {
      logic [POS_W-1:0] col_count;
      logic             store_ok;
      logic             emit;
      tag_type          tag;
   } pos_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                    input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = SIZE_W'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

@@ rtl/swc_ram.sv @@
`timescale 1ns / 1ps

module swc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ rtl/swc_position.sv @@
`timescale 1ns / 1ps

module swc_position #(
   parameter int KERNEL_ROWS = 3,
   parameter int KERNEL_COLS = 3,
   parameter int MAX_WIDTH   = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        frame_start,
   input  logic [swc_pkg::SIZE_W-1:0]  image_width,
   input  logic [swc_pkg::SIZE_W-1:0]  image_height,
   output swc_pkg::pos_type            pos
);

   localparam int PAD_Y = KERNEL_ROWS / 2;
   localparam int PAD_X = KERNEL_COLS / 2;
   localparam int CNT_W = swc_pkg::SIZE_W + 1;

   logic [swc_pkg::POS_W-1:0] row_ff, row_in;
   logic [swc_pkg::POS_W-1:0] col_ff, col_in;
   logic [swc_pkg::POS_W-1:0] row_cur, col_cur;
   logic [CNT_W-1:0]          row_next, col_next;
   logic [CNT_W-1:0]          pos_y, pos_x, far_y, far_x;
   logic [CNT_W-1:0]          width_ext, height_ext;

   always_comb begin
      row_cur    = frame_start ? '0 : row_ff;
      col_cur    = frame_start ? '0 : col_ff;
      row_next   = CNT_W'(row_cur) + CNT_W'(1);
      col_next   = CNT_W'(col_cur) + CNT_W'(1);
      width_ext  = CNT_W'(image_width);
      height_ext = CNT_W'(image_height);

      // Center of the window that the newest pixel completes.
      pos_y = row_next - CNT_W'(KERNEL_ROWS - PAD_Y);
      pos_x = col_next - CNT_W'(KERNEL_COLS - PAD_X);
      far_y = pos_y + CNT_W'(PAD_Y);
      far_x = pos_x + CNT_W'(PAD_X);

      pos.col_count      = col_cur;
      pos.store_ok       = (32'(col_cur) < MAX_WIDTH);
      pos.emit           = (row_next >= CNT_W'(KERNEL_ROWS)) &&
                           (col_next >= CNT_W'(KERNEL_COLS)) &&
                           (far_y < height_ext) && (far_x < width_ext);
      pos.tag.out_row    = pos_y[swc_pkg::POS_W-1:0];
      pos.tag.out_col    = pos_x[swc_pkg::POS_W-1:0];
      pos.tag.frame_done = (far_y + CNT_W'(1) == height_ext) &&
                           (far_x + CNT_W'(1) == width_ext);

      if (col_next >= width_ext) begin
         col_in = '0;
         row_in = (row_next >= height_ext) ? '0 : row_next[swc_pkg::POS_W-1:0];
      end else begin
         col_in = col_next[swc_pkg::POS_W-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

@@ rtl/swc_cell.sv @@
`timescale 1ns / 1ps

module swc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  logic [swc_pkg::PIXEL_W-1:0]         pixel_in,
   input  logic                                mult_en,
   input  logic signed [swc_pkg::COEF_W-1:0]   coef,
   output logic [swc_pkg::PIXEL_W-1:0]         pixel_out,
   output logic signed [swc_pkg::PROD_W-1:0]   product
);

   logic [swc_pkg::PIXEL_W-1:0]       pixel_ff;
   logic signed [swc_pkg::PROD_W-1:0] product_ff, product_in;

   assign product_in = $signed({1'b0, pixel_ff}) * coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
      end else if (shift_en) begin
         pixel_ff <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mult_en) begin
         product_ff <= product_in;
      end
   end

   assign pixel_out = pixel_ff;
   assign product   = product_ff;

endmodule

@@ rtl/sliding_window_convolution.sv @@
`timescale 1ns / 1ps

// 3x3 (by default) streaming convolution over one 8-bit image channel.
// The req channel takes one pixel per transfer in raster order; req_frame_start
// marks the first pixel of a frame. The rsp channel gives one transfer per
// interior position: the rounded, saturated sum with its row and column, and
// rsp_frame_done on the last interior result of a frame. Border positions
// give no transfer; the receiver fills them with zero.
// The csr port writes image width, image height and the three kernel rows;
// write only while the block is idle.
// Throughput is one pixel per cycle while no result is held back: each pixel
// takes one read and one write of the line-store RAM, and all kernel taps
// multiply in parallel cells. When the receiver stalls with a result pending,
// the whole pipeline holds and req_stall rises in the same cycle; it drops as
// soon as the result is taken.
// Synchronous reset clears the position counters, the window, the pipeline
// valids and the registers to their defaults. The line store is not cleared;
// every entry is written in the first row of a frame before it is used.
module sliding_window_convolution #(
   parameter int KERNEL_ROWS    = 3,
   parameter int KERNEL_COLS    = 3,
   parameter int MAX_WIDTH      = 4096,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [swc_pkg::PIXEL_W-1:0]           req_pixel_value,
   input  logic                                  req_frame_start,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [swc_pkg::PIXEL_W-1:0]           rsp_filtered_value,
   output logic [swc_pkg::POS_W-1:0]             rsp_out_row,
   output logic [swc_pkg::POS_W-1:0]             rsp_out_col,
   output logic                                  rsp_frame_done,

   input  logic                                  csr_write_enable,
   input  logic [swc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [swc_pkg::COEF_ROW_W-1:0]        csr_wdata
);

   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int LINE_W    = 2 * swc_pkg::PIXEL_W;
   localparam int WIDTH_MAX = (MAX_WIDTH < swc_pkg::MAX_SIZE) ? MAX_WIDTH : swc_pkg::MAX_SIZE;
   localparam int WIDTH_DEF = (WIDTH_MAX < swc_pkg::WIDTH_RESET) ? WIDTH_MAX
                                                                 : swc_pkg::WIDTH_RESET;
   localparam int SUM_W     = swc_pkg::SUM_W;
   localparam int ROW_W     = swc_pkg::ROW_SUM_W;
   localparam int PIX_W     = swc_pkg::PIXEL_W;

   localparam logic [SUM_W-1:0] FRAC_MASK =
      SUM_W'((64'(1) << COEF_FRAC_BITS) - 64'(1));
   localparam logic [SUM_W-1:0] FRAC_HALF =
      SUM_W'((64'(1) << COEF_FRAC_BITS) >> 1);

   // ---------------------------------------------------------------- csr
   logic [swc_pkg::SIZE_W-1:0]     width_ff, height_ff;
   logic [swc_pkg::COEF_ROW_W-1:0] coef_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= swc_pkg::SIZE_W'(WIDTH_DEF);
         height_ff  <= swc_pkg::SIZE_W'(swc_pkg::HEIGHT_RESET);
         coef_ff[0] <= swc_pkg::COEF_TOP_RESET;
         coef_ff[1] <= swc_pkg::COEF_MIDDLE_RESET;
         coef_ff[2] <= swc_pkg::COEF_BOTTOM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            swc_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= swc_pkg::clamp_size(csr_wdata[swc_pkg::SIZE_W-1:0],
                                               swc_pkg::SIZE_W'(WIDTH_MAX));
            end
            swc_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= swc_pkg::clamp_size(csr_wdata[swc_pkg::SIZE_W-1:0],
                                                swc_pkg::SIZE_W'(swc_pkg::MAX_SIZE));
            end
            swc_pkg::CSR_COEF_TOP:    coef_ff[0] <= csr_wdata;
            swc_pkg::CSR_COEF_MIDDLE: coef_ff[1] <= csr_wdata;
            swc_pkg::CSR_COEF_BOTTOM: coef_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- handshake
   logic advance;
   logic accept;
   logic rsp_valid_ff;

   // Every stage moves together unless a finished result is held back.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ------------------------------------------------------------ stage 0
   swc_pkg::pos_type pos;

   swc_position #(
      .KERNEL_ROWS (KERNEL_ROWS),
      .KERNEL_COLS (KERNEL_COLS),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_swc_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_start  (req_frame_start),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos)
   );

   // ------------------------------------------------------------ stage 1
   logic                    s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]        s1_pix_ff;
   swc_pkg::pos_type        s1_pos_ff;
   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [LINE_W-1:0]       ram_wdata, ram_rdata, line_data;
   logic                    byp_hit_ff, byp_hit_in;
   logic [LINE_W-1:0]       byp_data_ff;
   logic [PIX_W-1:0]        above1, above2;

   assign s1_valid_in = accept;
   assign ram_re      = accept && pos.store_ok;
   assign ram_raddr   = ADDR_W'(pos.col_count);
   assign ram_we      = advance && s1_valid_ff && s1_pos_ff.store_ok;
   assign ram_waddr   = ADDR_W'(s1_pos_ff.col_count);
   assign ram_wdata   = {above1, s1_pix_ff};

   // With a one-pixel row the next pixel reads the entry being written now.
   assign byp_hit_in  = ram_we && (ram_waddr == ram_raddr);
   assign line_data   = byp_hit_ff ? byp_data_ff : ram_rdata;
   assign above1      = s1_pos_ff.store_ok ? line_data[PIX_W-1:0] : '0;
   assign above2      = s1_pos_ff.store_ok ? line_data[LINE_W-1:PIX_W] : '0;

   swc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_swc_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_en    (ram_re),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (ram_re) begin
         byp_hit_ff  <= byp_hit_in;
         byp_data_ff <= ram_wdata;
      end
      if (accept) begin
         s1_pix_ff <= req_pixel_value;
         s1_pos_ff <= pos;
      end
   end

   // ------------------------------------------------------- window cells
   logic                              s2_valid_ff, s2_valid_in;
   logic                              s3_valid_ff, s3_valid_in;
   logic                              s4_valid_ff, s4_valid_in;
   logic                              s5_valid_ff, s5_valid_in;
   swc_pkg::tag_type                  s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff;
   logic [PIX_W-1:0]                  row_src [KERNEL_ROWS];
   logic [PIX_W-1:0]                  win [KERNEL_ROWS][KERNEL_COLS];
   logic signed [swc_pkg::PROD_W-1:0] prod [KERNEL_ROWS][KERNEL_COLS];

   assign s2_valid_in = s1_valid_ff && s1_pos_ff.emit;
   assign s3_valid_in = s2_valid_ff;
   assign s4_valid_in = s3_valid_ff;
   assign s5_valid_in = s4_valid_ff;

   for (genvar ky = 0; ky < KERNEL_ROWS; ky++) begin : g_row
      localparam int SRC = 3 - KERNEL_ROWS + ky;
      if (SRC == 0) begin : g_src_top
         assign row_src[ky] = above2;
      end else if (SRC == 1) begin : g_src_mid
         assign row_src[ky] = above1;
      end else begin : g_src_new
         assign row_src[ky] = s1_pix_ff;
      end

      for (genvar kx = 0; kx < KERNEL_COLS; kx++) begin : g_col
         logic [PIX_W-1:0] cell_in;
         if (kx == KERNEL_COLS - 1) begin : g_head
            assign cell_in = row_src[ky];
         end else begin : g_link
            assign cell_in = win[ky][kx+1];
         end

         swc_cell u_swc_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (advance && s1_valid_ff),
            .pixel_in  (cell_in),
            .mult_en   (advance && s2_valid_ff),
            .coef      ($signed(coef_ff[ky][swc_pkg::COEF_W*kx +: swc_pkg::COEF_W])),
            .pixel_out (win[ky][kx]),
            .product   (prod[ky][kx])
         );
      end
   end

   // --------------------------------------------------- adder stages 4, 5
   logic signed [ROW_W-1:0] row_sum_ff [KERNEL_ROWS];
   logic signed [ROW_W-1:0] row_sum_in [KERNEL_ROWS];
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      for (int ky = 0; ky < KERNEL_ROWS; ky++) begin
         row_sum_in[ky] = '0;
         for (int kx = 0; kx < KERNEL_COLS; kx++) begin
            row_sum_in[ky] = row_sum_in[ky] + ROW_W'(prod[ky][kx]);
         end
      end
      sum_in = '0;
      for (int ky = 0; ky < KERNEL_ROWS; ky++) begin
         sum_in = sum_in + SUM_W'(row_sum_ff[ky]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (s3_valid_ff) begin
            row_sum_ff <= row_sum_in;
         end
         if (s4_valid_ff) begin
            sum_ff <= sum_in;
         end
         s2_tag_ff <= s1_pos_ff.tag;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         s5_tag_ff <= s4_tag_ff;
      end
   end

   // ------------------------------------------------ round and saturate
   logic [SUM_W-1:0] magnitude, quotient, fraction, rounded;
   logic             round_up;
   logic [PIX_W-1:0] value_in;

   always_comb begin
      magnitude = sum_ff;
      quotient  = magnitude >> COEF_FRAC_BITS;
      fraction  = magnitude & FRAC_MASK;
      // Round to nearest, ties to even.
      round_up  = (COEF_FRAC_BITS > 0) &&
                  ((fraction > FRAC_HALF) || ((fraction == FRAC_HALF) && quotient[0]));
      rounded   = quotient + SUM_W'(round_up);
      if (sum_ff[SUM_W-1] || (sum_ff == '0)) begin
         value_in = '0;
      end else if (rounded > SUM_W'(swc_pkg::PIXEL_MAX)) begin
         value_in = swc_pkg::PIXEL_MAX;
      end else begin
         value_in = rounded[PIX_W-1:0];
      end
   end

   // ------------------------------------------------------- output stage
   logic [PIX_W-1:0] rsp_value_ff;
   swc_pkg::tag_type rsp_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s5_valid_ff) begin
         rsp_value_ff <= value_in;
         rsp_tag_ff   <= s5_tag_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_out_row        = rsp_tag_ff.out_row;
   assign rsp_out_col        = rsp_tag_ff.out_col;
   assign rsp_frame_done     = rsp_tag_ff.frame_done;

endmodule

@@ rtl/swc_checker.sv @@
`timescale 1ns / 1ps

module swc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [swc_pkg::PIXEL_W-1:0]   rsp_filtered_value,
   input logic [swc_pkg::POS_W-1:0]     rsp_out_row,
   input logic [swc_pkg::POS_W-1:0]     rsp_out_col,
   input logic                          rsp_frame_done
);

   // A result that is held back keeps its contents until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_value) &&
                                 $stable(rsp_out_row) && $stable(rsp_out_col) &&
                                 $stable(rsp_frame_done))
      else $error("rsp result changed while stalled");

   // The input side only waits behind a pending, stalled result.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // Reset empties the pipeline and opens the input side.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind sliding_window_convolution swc_checker u_swc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_filtered_value (rsp_filtered_value),
   .rsp_out_row        (rsp_out_row),
   .rsp_out_col        (rsp_out_col),
   .rsp_frame_done     (rsp_frame_done)
);
